>>> sv/distinct_source_dest_id_table_top_defines.svh
// ----------------------------------------------------------------------------
// Distinct ID table assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_SOURCE_DEST_ID_TABLE_TOP_DEFINES_SVH
`define DISTINCT_SOURCE_DEST_ID_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dit assertion failed");

// Next-cycle implication, disabled during reset
`define DIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dit assertion failed");

`endif

>>> sv/dit_pkg.sv
// ----------------------------------------------------------------------------
// Distinct ID table package
// Field widths and the structs passed between the top level and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dit_pkg;

    localparam int ID_W     = 16;  // source / destination ID width
    localparam int OIDX_W   = 6;   // index field width on the result
    localparam int OTOT_W   = 7;   // total field width on the result
    localparam int IN_DW    = 32;  // input tdata width
    localparam int OUT_DW   = 32;  // output tdata width
    localparam int OUT_UW   = 4;   // output tuser width

    // One pair of IDs: the query, or the pair of entries held by a cell
    typedef struct packed {
        logic [ID_W-1:0] dst_id;
        logic [ID_W-1:0] src_id;
    } t_query;

    // Per-table shift enables into the cell chain
    typedef struct packed {
        logic dst_en;
        logic src_en;
    } t_shift;

    // Per-table match flags from one cell
    typedef struct packed {
        logic dst;
        logic src;
    } t_hit;

endpackage

`default_nettype wire

>>> sv/dit_cell.sv
// ----------------------------------------------------------------------------
// Distinct ID table cell
// Holds one source entry and one destination entry. On an append the entry
// from the left neighbor moves in; the held entries are compared with the
// query when the cell lies inside the occupied part of its table.
// ----------------------------------------------------------------------------
`default_nettype none

module dit_cell
    import dit_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int POS   = 0
) (
    input  wire logic             i_clk,
    input  wire t_shift           i_shift,
    input  wire t_query           i_prev,      // entries of the left neighbor
    input  wire t_query           i_query,
    input  wire logic [CNT_W-1:0] i_src_used,
    input  wire logic [CNT_W-1:0] i_dst_used,
    output t_query                o_entry,
    output t_hit                  o_hit
);

    t_query r_entry;
    t_query n_entry;

    // Shift in from the neighbor, per table
    always_comb begin
        n_entry = r_entry;
        if (i_shift.src_en) begin
            n_entry.src_id = i_prev.src_id;
        end
        if (i_shift.dst_en) begin
            n_entry.dst_id = i_prev.dst_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // Occupied cells only; cell 0 holds the newest entry
    assign o_hit.src = (r_entry.src_id == i_query.src_id) && (CNT_W'(POS) < i_src_used);
    assign o_hit.dst = (r_entry.dst_id == i_query.dst_id) && (CNT_W'(POS) < i_dst_used);
    assign o_entry   = r_entry;

endmodule

`default_nettype wire

>>> sv/dit_enc.sv
// ----------------------------------------------------------------------------
// Distinct ID table match encoder
// Turns the match flags of the cell row into a cell position. A table never
// holds an ID twice, so at most one flag is set.
// ----------------------------------------------------------------------------
`default_nettype none

module dit_enc
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic [DEPTH-1:0] i_hit,
    output logic      [IDX_W-1:0] o_pos,
    output logic                  o_any
);

    // OR of the positions of all set flags
    always_comb begin
        o_pos = '0;
        for (int p = 0; p < DEPTH; p++) begin
            if (i_hit[p]) begin
                o_pos = o_pos | IDX_W'(p);
            end
        end
    end

    assign o_any = |i_hit;

endmodule

`default_nettype wire

>>> sv/distinct_source_dest_id_table_top.sv
// ----------------------------------------------------------------------------
// Distinct source / destination ID table
// Enumerates distinct source and destination IDs within a window.
// ----------------------------------------------------------------------------
// For each item the accept loads the query register; once the output register
// is free, the lookup compares the query against every cell of both tables at
// once, encodes the match and appends unseen IDs by shifting the cell row.
// The single query register keeps the input closed until the lookup is done.
// The result sits in an output register, so the next item is accepted while a
// result waits. Each table is a row of TABLE_DEPTH cells, the newest entry in
// cell 0; a fill count marks the occupied part, so no clearing pass runs after
// reset or at the end of a window. A full table drops unseen IDs and flags them.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_source_dest_id_table_top
    import dit_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [IN_DW-1:0]  i_s_axis_tdata,   // source_id, dest_id
    input  wire logic              i_s_axis_tlast,   // last_in_window
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [OUT_DW-1:0]      o_m_axis_tdata,   // source_index, dest_index,
                                                     // source_total, dest_total
    output logic [OUT_UW-1:0]      o_m_axis_tuser,   // source_new, dest_new,
                                                     // source_full, dest_full
    output logic                   o_m_axis_tlast    // window_done
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Control and query registers
    logic             r_busy;
    t_query           r_query;
    logic             r_last;
    logic [CNT_W-1:0] r_src_used;
    logic [CNT_W-1:0] r_dst_used;

    // Result register
    logic              r_out_valid;
    logic [OUT_DW-1:0] r_out_data;
    logic [OUT_UW-1:0] r_out_user;
    logic              r_out_last;

    logic accept;
    logic fire;

    assign o_s_axis_tready = !r_busy;
    assign accept          = i_s_axis_tvalid && !r_busy;
    assign fire            = r_busy && (!r_out_valid || i_m_axis_tready);

    // Cell row
    t_query               w_entry [TABLE_DEPTH];
    t_hit                 w_hit   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_src_hit;
    logic [TABLE_DEPTH-1:0] w_dst_hit;
    t_shift               w_shift;

    for (genvar p = 0; p < TABLE_DEPTH; p++) begin : g_cell
        t_query w_prev;
        if (p == 0) begin : g_head
            assign w_prev = r_query;
        end else begin : g_link
            assign w_prev = w_entry[p-1];
        end
        dit_cell #(
            .CNT_W (CNT_W),
            .POS   (p)
        ) u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_shift),
            .i_prev     (w_prev),
            .i_query    (r_query),
            .i_src_used (r_src_used),
            .i_dst_used (r_dst_used),
            .o_entry    (w_entry[p]),
            .o_hit      (w_hit[p])
        );
        assign w_src_hit[p] = w_hit[p].src;
        assign w_dst_hit[p] = w_hit[p].dst;
    end

    // Match position per table
    logic [IDX_W-1:0] w_src_pos;
    logic [IDX_W-1:0] w_dst_pos;
    logic             w_src_any;
    logic             w_dst_any;

    dit_enc #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_src_enc (
        .i_hit (w_src_hit),
        .o_pos (w_src_pos),
        .o_any (w_src_any)
    );

    dit_enc #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_dst_enc (
        .i_hit (w_dst_hit),
        .o_pos (w_dst_pos),
        .o_any (w_dst_any)
    );

    // Lookup outcome per table: known, appended or dropped
    logic [IDX_W-1:0] w_src_idx;
    logic [IDX_W-1:0] w_dst_idx;
    logic             w_src_new;
    logic             w_dst_new;
    logic             w_src_full;
    logic             w_dst_full;
    logic [CNT_W-1:0] w_src_tot;
    logic [CNT_W-1:0] w_dst_tot;

    always_comb begin
        w_src_idx  = '0;
        w_src_new  = 1'b0;
        w_src_full = 1'b0;
        w_src_tot  = r_src_used;
        if (w_src_any) begin
            // cell p holds the entry appended as number used-1-p
            w_src_idx = IDX_W'(r_src_used - CNT_W'(1) - CNT_W'(w_src_pos));
        end else if (r_src_used < CNT_W'(TABLE_DEPTH)) begin
            w_src_idx = IDX_W'(r_src_used);
            w_src_new = 1'b1;
            w_src_tot = r_src_used + CNT_W'(1);
        end else begin
            w_src_full = 1'b1;
        end
    end

    always_comb begin
        w_dst_idx  = '0;
        w_dst_new  = 1'b0;
        w_dst_full = 1'b0;
        w_dst_tot  = r_dst_used;
        if (w_dst_any) begin
            w_dst_idx = IDX_W'(r_dst_used - CNT_W'(1) - CNT_W'(w_dst_pos));
        end else if (r_dst_used < CNT_W'(TABLE_DEPTH)) begin
            w_dst_idx = IDX_W'(r_dst_used);
            w_dst_new = 1'b1;
            w_dst_tot = r_dst_used + CNT_W'(1);
        end else begin
            w_dst_full = 1'b1;
        end
    end

    assign w_shift.src_en = fire && w_src_new;
    assign w_shift.dst_en = fire && w_dst_new;

    // Fit internal widths to the result field widths
    logic [IDX_W+OIDX_W-1:0] w_src_idx_x;
    logic [IDX_W+OIDX_W-1:0] w_dst_idx_x;
    logic [CNT_W+OTOT_W-1:0] w_src_tot_x;
    logic [CNT_W+OTOT_W-1:0] w_dst_tot_x;

    assign w_src_idx_x = {{OIDX_W{1'b0}}, w_src_idx};
    assign w_dst_idx_x = {{OIDX_W{1'b0}}, w_dst_idx};
    assign w_src_tot_x = {{OTOT_W{1'b0}}, w_src_tot};
    assign w_dst_tot_x = {{OTOT_W{1'b0}}, w_dst_tot};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_src_used  <= '0;
            r_dst_used  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (fire) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_src_used  <= r_last ? '0 : w_src_tot;
                r_dst_used  <= r_last ? '0 : w_dst_tot;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Query and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_query.src_id <= i_s_axis_tdata[ID_W-1:0];
            r_query.dst_id <= i_s_axis_tdata[2*ID_W-1:ID_W];
            r_last         <= i_s_axis_tlast;
        end
        if (fire) begin
            r_out_data <= {6'd0, w_dst_tot_x[OTOT_W-1:0], w_src_tot_x[OTOT_W-1:0],
                           w_dst_idx_x[OIDX_W-1:0], w_src_idx_x[OIDX_W-1:0]};
            r_out_user <= {w_dst_full, w_src_full, w_dst_new, w_src_new};
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> sv/dit_checker.sv
// ----------------------------------------------------------------------------
// Distinct ID table port checker
// Watches the ports of the top level and checks result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distinct_source_dest_id_table_top_defines.svh"

module dit_checker
    import dit_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_axis_tvalid,
    input wire logic              o_s_axis_tready,
    input wire logic              o_m_axis_tvalid,
    input wire logic              i_m_axis_tready,
    input wire logic [OUT_DW-1:0] o_m_axis_tdata,   // indexes, totals
    input wire logic [OUT_UW-1:0] o_m_axis_tuser,   // new and full flags
    input wire logic              o_m_axis_tlast    // window_done
);

    // A stalled result holds its payload
    `DIT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))

    // An accepted item closes the input while its lookup is pending
    `DIT_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready,
        !o_s_axis_tready)

    // An appended source gets the highest index, its total minus one, and is not flagged full
    `DIT_ASSERT_NOW(a_src_new_idx, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0],
        !o_m_axis_tuser[2] && (o_m_axis_tdata[5:0] == 6'(o_m_axis_tdata[18:12] - 7'd1)))

    // A dropped destination reports index zero and no append
    `DIT_ASSERT_NOW(a_dst_full_idx, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[3],
        !o_m_axis_tuser[1] && (o_m_axis_tdata[11:6] == 6'd0))

endmodule

bind distinct_source_dest_id_table_top dit_checker u_dit_checker (.*);

`default_nettype wire
